// ----- rtl/x11rsh_pkg.sv -----
// Package for the X11 request stream histogram unit.
// Holds the code types, protocol constants and byte-order helpers; depends on nothing.
`default_nettype none

package x11rsh_pkg;

   localparam int DEF_COUNT_WIDTH = 32;
   localparam int DEF_BYTES_WIDTH = 48;
   localparam int LEN_WIDTH       = 34;
   localparam int NUM_OPCODES     = 256;
   localparam int SETUP_LEN       = 12;
   localparam int REQ_HDR_LEN     = 4;
   localparam int BIG_HDR_LEN     = 8;
   localparam logic [7:0] BYTE_ORDER_LE = 8'h6C;

   typedef enum logic {
      OP_FEED = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic {
      KIND_REQUEST = 1'b0,
      KIND_ENTRY   = 1'b1
   } kind_type;

   // Two stream bytes as a 16-bit value in the negotiated byte order.
   function automatic logic [15:0] get16(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic le);
      return le ? {b1, b0} : {b0, b1};
   endfunction

   // Four stream bytes as a 32-bit value in the negotiated byte order.
   function automatic logic [31:0] get32(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic le);
      return le ? {b3, b2, b1, b0} : {b0, b1, b2, b3};
   endfunction

   // Length rounded up to a multiple of four.
   function automatic logic [16:0] pad4(input logic [15:0] len);
      logic [16:0] sum;
      sum = {1'b0, len} + 17'd3;
      return {sum[16:2], 2'b00};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/x11_request_stream_histogram_unit.sv -----
// Top level of the X11 request stream histogram unit: parser, opcode histogram, result register.
// Depends on x11rsh_pkg.
//
// Usage: the req_ channel carries one beat per clock at most. A beat with operation FEED
// hands one client-to-server stream byte to the parser; a beat with operation READ asks
// for the histogram entry of one major opcode. The parser skips the setup block and the
// body of every request; each completed request header gives one rsp_ beat (kind
// REQUEST) and updates the entry of its opcode. A READ beat always gives one rsp_ beat
// (kind ENTRY). Stream bytes that complete no header give no beat.
// The block takes one beat every cycle while rsp_tready keeps up: the parser is
// combinational behind the input register, and the histogram memory is read as an
// item enters stage 2 and written as a request leaves it, with a bypass register
// so that back-to-back accesses to one opcode see the newest value.
// Reset clears the parser and the valid bit of every histogram entry at once, so all
// counters read as zero right after reset with no clearing pass.
// When the receiver stalls, the result register holds its beat; an item that gives no
// result still passes, and req_tready falls only once the pipeline behind it is full.
`default_nettype none

module x11_request_stream_histogram_unit #(
   parameter int COUNT_WIDTH = x11rsh_pkg::DEF_COUNT_WIDTH,
   parameter int BYTES_WIDTH = x11rsh_pkg::DEF_BYTES_WIDTH,
   localparam int RspFieldWidth = 8 + x11rsh_pkg::LEN_WIDTH + 8 + 2 * COUNT_WIDTH + BYTES_WIDTH,
   localparam int RspDataWidth  = ((RspFieldWidth + 7) / 8) * 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // data_byte [7:0], chunk_fds [15:8], read_index [23:16]
   input  wire logic [23:0]             req_tdata,
   // operation [0], chunk_start [1]
   input  wire logic [1:0]              req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // major_opcode, request_bytes, request_fds, entry_count, entry_bytes, entry_fds
   output logic [RspDataWidth-1:0]      rsp_tdata,
   // record_kind [0]
   output logic [0:0]                   rsp_tuser
);

   localparam int LenW     = x11rsh_pkg::LEN_WIDTH;
   localparam int NumOp    = x11rsh_pkg::NUM_OPCODES;
   localparam int BSumW    = (BYTES_WIDTH > LenW ? BYTES_WIDTH : LenW) + 1;

   // Handshake enables along the pipeline.
   logic en1, en2, s2_go, wr_en;

   // Input register.
   logic                 s1_valid_ff;
   x11rsh_pkg::op_type   s1_op_ff;
   logic [7:0]           s1_byte_ff, s1_fds_ff, s1_idx_ff;
   logic                 s1_start_ff;

   // Parser state.
   logic                 setup_seen_ff, setup_seen_in;
   logic                 le_ff, le_in;
   logic [7:0]           hdr_ff [0:x11rsh_pkg::SETUP_LEN-1];
   logic [7:0]           hdr_in [0:x11rsh_pkg::SETUP_LEN-1];
   logic [3:0]           fill_ff, fill_in;
   logic [LenW-1:0]      skip_ff, skip_in;
   logic [7:0]           pending_ff, pending_in;

   // Stage 1 results.
   logic                 s1_event;
   x11rsh_pkg::kind_type s1_kind;
   logic [7:0]           s1_addr;
   logic [LenW-1:0]      s1_len;
   logic [7:0]           s1_rfds;

   // Stage 2.
   logic                 s2_valid_ff;
   x11rsh_pkg::kind_type s2_kind_ff;
   logic [7:0]           s2_major_ff;
   logic [LenW-1:0]      s2_len_ff;
   logic [7:0]           s2_fds_ff;

   // Histogram memory and its read and bypass registers.
   logic [COUNT_WIDTH-1:0] mem_count [0:NumOp-1];
   logic [BYTES_WIDTH-1:0] mem_bytes [0:NumOp-1];
   logic [COUNT_WIDTH-1:0] mem_fds   [0:NumOp-1];
   logic [NumOp-1:0]       vld_ff;
   logic [COUNT_WIDTH-1:0] rd_count_ff, byp_count_ff, cur_count, new_count;
   logic [BYTES_WIDTH-1:0] rd_bytes_ff, byp_bytes_ff, cur_bytes, new_bytes;
   logic [COUNT_WIDTH-1:0] rd_fds_ff, byp_fds_ff, cur_fds, new_fds;
   logic                   rd_vld_ff, byp_sel_ff;
   logic [COUNT_WIDTH:0]   count_sum, fds_sum;
   logic [BSumW-1:0]       bytes_sum;

   // Result register.
   logic                   rsp_valid_ff;
   x11rsh_pkg::kind_type   rsp_kind_ff;
   logic [7:0]             rsp_major_ff;
   logic [LenW-1:0]        rsp_len_ff;
   logic [7:0]             rsp_rfds_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_efds_ff;
   logic [BYTES_WIDTH-1:0] rsp_bytes_ff;

   assign s2_go      = !rsp_valid_ff || rsp_tready;
   assign en2        = !s2_valid_ff || s2_go;
   assign en1        = !s1_valid_ff || en2;
   assign req_tready = en1;
   assign wr_en      = s2_valid_ff && s2_go && (s2_kind_ff == x11rsh_pkg::KIND_REQUEST);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_tvalid;
      end
      if (en1) begin
         s1_op_ff    <= x11rsh_pkg::op_type'(req_tuser[0]);
         s1_start_ff <= req_tuser[1];
         s1_byte_ff  <= req_tdata[7:0];
         s1_fds_ff   <= req_tdata[15:8];
         s1_idx_ff   <= req_tdata[23:16];
      end
   end

   // Parser: one stream byte per cycle, unless the pipeline stalls, against the header collected so far.
   always_comb begin
      logic [3:0]      fill_idx;
      logic [3:0]      fill_nx;
      logic            le_new;
      logic            done;
      logic [15:0]     len16;
      logic [LenW-1:0] len;
      logic [17:0]     auth_len;
      setup_seen_in = setup_seen_ff;
      le_in         = le_ff;
      hdr_in        = hdr_ff;
      fill_in       = fill_ff;
      skip_in       = skip_ff;
      pending_in    = s1_start_ff ? s1_fds_ff : pending_ff;
      s1_event      = 1'b0;
      s1_kind       = x11rsh_pkg::KIND_ENTRY;
      s1_addr       = s1_idx_ff;
      s1_len        = '0;
      s1_rfds       = pending_in;
      done          = 1'b0;
      len           = '0;
      fill_idx      = (fill_ff >= 4'(x11rsh_pkg::SETUP_LEN)) ? 4'd0 : fill_ff;
      fill_nx       = fill_idx + 4'd1;
      le_new        = 1'b0;
      len16         = '0;
      auth_len      = '0;
      if (s1_op_ff == x11rsh_pkg::OP_READ) begin
         pending_in = pending_ff;
         s1_event   = 1'b1;
      end else if (skip_ff != '0) begin
         skip_in = skip_ff - LenW'(1);
      end else begin
         hdr_in[fill_idx] = s1_byte_ff;
         fill_in          = fill_nx;
         if (!setup_seen_ff) begin
            if (fill_nx == 4'(x11rsh_pkg::SETUP_LEN)) begin
               le_new        = (hdr_in[0] == x11rsh_pkg::BYTE_ORDER_LE);
               auth_len      = 18'(x11rsh_pkg::pad4(x11rsh_pkg::get16(hdr_in[6], hdr_in[7],
                                                                     le_new)))
                             + 18'(x11rsh_pkg::pad4(x11rsh_pkg::get16(hdr_in[8], hdr_in[9],
                                                                     le_new)));
               le_in         = le_new;
               skip_in       = LenW'(auth_len);
               setup_seen_in = 1'b1;
               fill_in       = '0;
            end
         end else if (fill_nx >= 4'(x11rsh_pkg::REQ_HDR_LEN)) begin
            len16 = x11rsh_pkg::get16(hdr_in[2], hdr_in[3], le_ff);
            if (len16 != '0) begin
               len  = LenW'({len16, 2'b00});
               done = 1'b1;
            end else if (fill_nx >= 4'(x11rsh_pkg::BIG_HDR_LEN)) begin
               len  = LenW'({x11rsh_pkg::get32(hdr_in[4], hdr_in[5], hdr_in[6], hdr_in[7],
                                               le_ff), 2'b00});
               done = 1'b1;
            end
         end
         if (done) begin
            s1_event   = 1'b1;
            s1_kind    = x11rsh_pkg::KIND_REQUEST;
            s1_addr    = hdr_in[0];
            s1_len     = len;
            pending_in = '0;
            skip_in    = (len > LenW'(fill_nx)) ? len - LenW'(fill_nx) : '0;
            fill_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_seen_ff <= 1'b0;
         le_ff         <= 1'b0;
         fill_ff       <= '0;
         skip_ff       <= '0;
         pending_ff    <= '0;
      end else if (en2 && s1_valid_ff) begin
         setup_seen_ff <= setup_seen_in;
         le_ff         <= le_in;
         fill_ff       <= fill_in;
         skip_ff       <= skip_in;
         pending_ff    <= pending_in;
      end
      if (en2 && s1_valid_ff) begin
         hdr_ff <= hdr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff && s1_event;
      end
      if (en2) begin
         s2_kind_ff  <= s1_kind;
         s2_major_ff <= s1_addr;
         s2_len_ff   <= s1_len;
         s2_fds_ff   <= s1_rfds;
      end
   end

   // Histogram memory: written as a request record leaves stage 2, read as an item enters it.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_count[s2_major_ff] <= new_count;
         mem_bytes[s2_major_ff] <= new_bytes;
         mem_fds[s2_major_ff]   <= new_fds;
      end
      if (en2) begin
         rd_count_ff <= mem_count[s1_addr];
         rd_bytes_ff <= mem_bytes[s1_addr];
         rd_fds_ff   <= mem_fds[s1_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[s2_major_ff] <= 1'b1;
      end
      if (en2) begin
         rd_vld_ff    <= vld_ff[s1_addr];
         byp_sel_ff   <= wr_en && (s2_major_ff == s1_addr);
         byp_count_ff <= new_count;
         byp_bytes_ff <= new_bytes;
         byp_fds_ff   <= new_fds;
      end
   end

   // Current entry value and its saturating update.
   always_comb begin
      if (byp_sel_ff) begin
         cur_count = byp_count_ff;
         cur_bytes = byp_bytes_ff;
         cur_fds   = byp_fds_ff;
      end else if (rd_vld_ff) begin
         cur_count = rd_count_ff;
         cur_bytes = rd_bytes_ff;
         cur_fds   = rd_fds_ff;
      end else begin
         cur_count = '0;
         cur_bytes = '0;
         cur_fds   = '0;
      end
      count_sum = {1'b0, cur_count} + (COUNT_WIDTH + 1)'(1);
      fds_sum   = {1'b0, cur_fds} + (COUNT_WIDTH + 1)'(s2_fds_ff);
      bytes_sum = BSumW'(cur_bytes) + BSumW'(s2_len_ff);
      new_count = count_sum[COUNT_WIDTH] ? '1 : count_sum[COUNT_WIDTH-1:0];
      new_fds   = fds_sum[COUNT_WIDTH] ? '1 : fds_sum[COUNT_WIDTH-1:0];
      new_bytes = (bytes_sum > BSumW'({BYTES_WIDTH{1'b1}})) ? '1
                                                           : bytes_sum[BYTES_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_go) begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (s2_go && s2_valid_ff) begin
         rsp_kind_ff  <= s2_kind_ff;
         rsp_major_ff <= s2_major_ff;
         if (s2_kind_ff == x11rsh_pkg::KIND_REQUEST) begin
            rsp_len_ff   <= s2_len_ff;
            rsp_rfds_ff  <= s2_fds_ff;
            rsp_count_ff <= '0;
            rsp_bytes_ff <= '0;
            rsp_efds_ff  <= '0;
         end else begin
            rsp_len_ff   <= '0;
            rsp_rfds_ff  <= '0;
            rsp_count_ff <= cur_count;
            rsp_bytes_ff <= cur_bytes;
            rsp_efds_ff  <= cur_fds;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = RspDataWidth'({rsp_efds_ff, rsp_bytes_ff, rsp_count_ff,
                                      rsp_rfds_ff, rsp_len_ff, rsp_major_ff});

endmodule

`default_nettype wire
